>>> src/json_string_unescape_utf8_macros.svh
// Assertion macros shared by the string unescape modules
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// check a property on every rising edge outside reset
`define JSU_ASSERT(label, clk_s, rst_s, prop) \
	label: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
		else $error("%m: check failed");

// check that a condition never holds
`define JSU_NEVER(label, clk_s, rst_s, expr) \
	`JSU_ASSERT(label, clk_s, rst_s, !(expr))

`endif

>>> src/jsu_pkg.sv
// Types, codes and the UTF-8 encoder shared by the string unescape modules
`default_nettype none
package jsu_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [2:0] KIND_DATA   = 3'd0;
	localparam logic [2:0] KIND_CLOSED = 3'd1;
	localparam logic [2:0] KIND_START  = 3'd2;
	localparam logic [2:0] KIND_ESC    = 3'd3;
	localparam logic [2:0] KIND_HEX    = 3'd4;
	localparam logic [2:0] KIND_SURR   = 3'd5;
	localparam logic [2:0] KIND_UNTERM = 3'd6;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_last_byte;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] kind;
		logic       last;
	} out_t;

	// all results caused by one input transaction
	typedef struct packed {
		logic [2:0]      n_data;
		logic [3:0][7:0] data;
		logic            has_tail;
		logic [2:0]      tail_kind;
	} grp_t;

	typedef struct packed {
		logic [2:0]      n;
		logic [3:0][7:0] b;
	} utf8_t;

	function automatic utf8_t utf8_enc(input logic [20:0] cp);
		utf8_t r;
		r = '0;
		if (cp == 21'h0) begin
			r.n = 3'd0;
		end else if (cp < 21'h80) begin
			r.n    = 3'd1;
			r.b[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			r.n    = 3'd2;
			r.b[0] = {3'b110, cp[10:6]};
			r.b[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			r.n    = 3'd3;
			r.b[0] = {4'b1110, cp[15:12]};
			r.b[1] = {2'b10, cp[11:6]};
			r.b[2] = {2'b10, cp[5:0]};
		end else begin
			r.n    = 3'd4;
			r.b[0] = {5'b11110, cp[20:18]};
			r.b[1] = {2'b10, cp[17:12]};
			r.b[2] = {2'b10, cp[11:6]};
			r.b[3] = {2'b10, cp[5:0]};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/jsu_front.sv
// Front end: parses one byte per cycle while take is high and builds its result group
`default_nettype none
`include "json_string_unescape_utf8_macros.svh"
module jsu_front import jsu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic take,
	input  wire in_t  item,
	output logic      grp_valid,
	output grp_t      grp
);

	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_BODY    = 3'd1;
	localparam logic [2:0] MODE_ESC     = 3'd2;
	localparam logic [2:0] MODE_HEX     = 3'd3;
	localparam logic [2:0] MODE_WAIT_BS = 3'd4;
	localparam logic [2:0] MODE_WAIT_U  = 3'd5;
	localparam logic [2:0] MODE_LOW_HEX = 3'd6;

	logic [2:0]  mode_q, mode_d;
	logic [15:0] acc_q, acc_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [15:0] hs_q, hs_d;
	logic [7:0]  c;
	logic [3:0]  digit;
	logic        is_hex;
	logic [15:0] acc_new;
	logic        err;
	utf8_t       enc;
	grp_t        g;

	assign c = item.in_byte;

	always_comb begin
		is_hex = 1'b1;
		digit  = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			digit = 4'(c - 8'h30);
		end else if (c inside {[8'h61:8'h66]}) begin
			digit = 4'(c - 8'h57);
		end else if (c inside {[8'h41:8'h46]}) begin
			digit = 4'(c - 8'h37);
		end else begin
			is_hex = 1'b0;
		end
	end

	assign acc_new = {acc_q[11:0], digit};

	always_comb begin
		if (mode_q == MODE_LOW_HEX) begin
			enc = utf8_enc(21'h10000 + {1'b0, hs_q[9:0], acc_new[9:0]});
		end else begin
			enc = utf8_enc({5'd0, acc_new});
		end
	end

	always_comb begin
		mode_d = mode_q;
		acc_d  = acc_q;
		cnt_d  = cnt_q;
		hs_d   = hs_q;
		err    = 1'b0;
		g      = '0;
		case (mode_q)
			MODE_BODY: begin
				if (c == 8'h22) begin
					g.has_tail  = 1'b1;
					g.tail_kind = KIND_CLOSED;
					mode_d      = MODE_IDLE;
				end else if (c == 8'h5C) begin
					mode_d = MODE_ESC;
				end else begin
					g.n_data  = 3'd1;
					g.data[0] = c;
				end
			end
			MODE_ESC: begin
				mode_d   = MODE_BODY;
				g.n_data = 3'd1;
				case (c)
					8'h22: g.data[0] = 8'h22;
					8'h5C: g.data[0] = 8'h5C;
					8'h2F: g.data[0] = 8'h2F;
					8'h62: g.data[0] = 8'h08;
					8'h66: g.data[0] = 8'h0C;
					8'h6E: g.data[0] = 8'h0A;
					8'h72: g.data[0] = 8'h0D;
					8'h74: g.data[0] = 8'h09;
					8'h75: begin
						g.n_data = 3'd0;
						mode_d   = MODE_HEX;
						acc_d    = '0;
						cnt_d    = '0;
					end
					default: begin
						g.n_data = 3'd0;
						err      = 1'b1;
					end
				endcase
				if (err) begin
					g.has_tail  = 1'b1;
					g.tail_kind = KIND_ESC;
					mode_d      = MODE_IDLE;
				end
			end
			MODE_HEX, MODE_LOW_HEX: begin
				if (!is_hex) begin
					err         = 1'b1;
					g.has_tail  = 1'b1;
					g.tail_kind = KIND_HEX;
					mode_d      = MODE_IDLE;
				end else begin
					acc_d = acc_new;
					if (cnt_q != 2'd3) begin
						cnt_d = cnt_q + 2'd1;
					end else begin
						cnt_d = '0;
						if (mode_q == MODE_HEX) begin
							if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
								hs_d   = acc_new;
								mode_d = MODE_WAIT_BS;
							end else begin
								g.n_data = enc.n;
								g.data   = enc.b;
								mode_d   = MODE_BODY;
							end
						end else if (acc_new < 16'hDC00 || acc_new > 16'hDFFF) begin
							err         = 1'b1;
							g.has_tail  = 1'b1;
							g.tail_kind = KIND_SURR;
							mode_d      = MODE_IDLE;
						end else begin
							g.n_data = enc.n;
							g.data   = enc.b;
							mode_d   = MODE_BODY;
						end
					end
				end
			end
			MODE_WAIT_BS: begin
				if (c == 8'h5C) begin
					mode_d = MODE_WAIT_U;
				end else begin
					err         = 1'b1;
					g.has_tail  = 1'b1;
					g.tail_kind = KIND_SURR;
					mode_d      = MODE_IDLE;
				end
			end
			MODE_WAIT_U: begin
				if (c == 8'h75) begin
					mode_d = MODE_LOW_HEX;
					acc_d  = '0;
					cnt_d  = '0;
				end else begin
					err         = 1'b1;
					g.has_tail  = 1'b1;
					g.tail_kind = KIND_SURR;
					mode_d      = MODE_IDLE;
				end
			end
			default: begin
				if (c == 8'h22) begin
					mode_d = MODE_BODY;
				end else begin
					err         = 1'b1;
					g.has_tail  = 1'b1;
					g.tail_kind = KIND_START;
					mode_d      = MODE_IDLE;
				end
			end
		endcase
		if (item.is_last_byte && !err && mode_d != MODE_IDLE) begin
			g.has_tail  = 1'b1;
			g.tail_kind = KIND_UNTERM;
			mode_d      = MODE_IDLE;
		end
	end

	assign grp       = g;
	assign grp_valid = take && (g.n_data != 3'd0 || g.has_tail);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= '0;
			cnt_q  <= '0;
			hs_q   <= '0;
		end else if (take) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			cnt_q  <= cnt_d;
			hs_q   <= hs_d;
		end
	end

	`JSU_NEVER(a_err_alone, clk, arst_n,
		grp_valid && grp.has_tail && grp.tail_kind != KIND_CLOSED &&
		grp.tail_kind != KIND_UNTERM && grp.n_data != 3'd0)

endmodule
`default_nettype wire

>>> src/jsu_queue.sv
// Short queue of result groups between the front and back ends
`default_nettype none
`include "json_string_unescape_utf8_macros.svh"
module jsu_queue import jsu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire grp_t wr_data,
	output logic      q_full,
	input  wire logic rd,
	output logic      q_empty,
	output grp_t      rd_data
);

	grp_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign q_full  = (cnt_q == QCNT_W'(QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`JSU_NEVER(a_rd_empty, clk, arst_n, rd && q_empty)

endmodule
`default_nettype wire

>>> src/jsu_back.sv
// Back end: serializes each result group into single result transactions
`default_nettype none
`include "json_string_unescape_utf8_macros.svh"
module jsu_back import jsu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_empty,
	input  wire grp_t q_data,
	output logic      q_rd,
	input  wire logic pop,
	output logic      empty,
	output out_t      result
);

	grp_t       g_q;
	logic       gv_q;
	logic [2:0] idx_q;
	logic [2:0] total;
	logic       at_end;

	assign total  = g_q.n_data + {2'd0, g_q.has_tail};
	assign at_end = (idx_q == total - 3'd1);
	assign empty  = !gv_q;
	assign q_rd   = !q_empty && (!gv_q || (pop && at_end));

	always_comb begin
		result.last = at_end;
		if (idx_q < g_q.n_data) begin
			result.out_byte = g_q.data[idx_q[1:0]];
			result.kind     = KIND_DATA;
		end else begin
			result.out_byte = 8'h00;
			result.kind     = g_q.tail_kind;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			g_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gv_q  <= 1'b0;
			idx_q <= '0;
		end else if (q_rd) begin
			gv_q  <= 1'b1;
			idx_q <= '0;
		end else if (gv_q && pop) begin
			if (at_end) begin
				gv_q  <= 1'b0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	`JSU_NEVER(a_idx_range, clk, arst_n, gv_q && idx_q >= total)

endmodule
`default_nettype wire

>>> src/json_string_unescape_utf8.sv
// Top level of the quoted string unescape decoder with UTF-8 output
//
//   channel  | handshake    | payload
//   ---------+--------------+-------------------------------
//   input    | push / full  | item   (in_byte, is_last_byte)
//   result   | pop / empty  | result (out_byte, kind, last)
//
// One input byte is parsed each cycle while full is low; its 0 to 5 results go into a
// four-group queue and leave one per cycle while pop is held, from the back end's group register.
// Throughput on the result side is one result per cycle, so inputs that expand to
// several bytes fill the queue and assert full.
// Reset clears the parser state, empties the queue and marks the result register empty.
`default_nettype none
`include "json_string_unescape_utf8_macros.svh"
module json_string_unescape_utf8 import jsu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic      full,
	input  wire in_t  item,
	input  wire logic pop,
	output logic      empty,
	output out_t      result
);

	logic take;
	logic grp_valid;
	grp_t grp;
	logic q_full;
	logic q_empty;
	logic q_rd;
	grp_t q_data;

	assign full = q_full;
	assign take = push && !q_full;

	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.item      (item),
		.grp_valid (grp_valid),
		.grp       (grp)
	);

	jsu_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (grp_valid),
		.wr_data (grp),
		.q_full  (q_full),
		.rd      (q_rd),
		.q_empty (q_empty),
		.rd_data (q_data)
	);

	jsu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_rd    (q_rd),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

	`JSU_NEVER(a_no_overflow, clk, arst_n, grp_valid && q_full)

endmodule
`default_nettype wire

>>> sim/tb.sv
// Testbench for json_string_unescape_utf8: directed byte table, random literals, queue checks
`default_nettype none
module tb;
	import jsu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		M_IDLE, M_BODY, M_ESC, M_HEX, M_WAIT_BS, M_WAIT_U, M_LOW_HEX
	} dec_mode_t;

	typedef struct packed {
		logic [7:0] b;
		logic       lst;
		logic       typed;
		out_t       want;
	} byte_row_t;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] ESC_LETTERS [8] = '{
		CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T
	};
	localparam out_t NO_RES = '0;
	localparam int NUM_ROWS = 28;
	localparam int RANDOM_ITEMS = 380;

	localparam byte_row_t DIRECTED_BYTES [NUM_ROWS] = '{
		'{8'h41, 1'b0, 1'b1, '{8'h00, KIND_START, 1'b1}},
		'{8'h00, 1'b1, 1'b1, '{8'h00, KIND_START, 1'b1}},
		'{CH_QUOTE, 1'b1, 1'b1, '{8'h00, KIND_UNTERM, 1'b1}},
		'{CH_QUOTE, 1'b0, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b1, '{8'hFF, KIND_DATA, 1'b1}},
		'{CH_BSLASH, 1'b0, 1'b0, NO_RES},
		'{8'h71, 1'b0, 1'b1, '{8'h00, KIND_ESC, 1'b1}},
		'{CH_QUOTE, 1'b0, 1'b0, NO_RES},
		'{CH_BSLASH, 1'b0, 1'b0, NO_RES},
		'{CH_U, 1'b0, 1'b0, NO_RES},
		'{8'h44, 1'b0, 1'b0, NO_RES},
		'{8'h42, 1'b0, 1'b0, NO_RES},
		'{8'h46, 1'b0, 1'b0, NO_RES},
		'{8'h66, 1'b0, 1'b0, NO_RES},
		'{CH_BSLASH, 1'b0, 1'b0, NO_RES},
		'{8'h78, 1'b0, 1'b1, '{8'h00, KIND_SURR, 1'b1}},
		'{CH_QUOTE, 1'b0, 1'b0, NO_RES},
		'{CH_BSLASH, 1'b0, 1'b0, NO_RES},
		'{CH_U, 1'b0, 1'b0, NO_RES},
		'{8'h30, 1'b0, 1'b0, NO_RES},
		'{8'h30, 1'b0, 1'b0, NO_RES},
		'{8'h30, 1'b0, 1'b0, NO_RES},
		'{8'h30, 1'b0, 1'b0, NO_RES},
		'{CH_BSLASH, 1'b0, 1'b0, NO_RES},
		'{CH_U, 1'b0, 1'b0, NO_RES},
		'{8'h67, 1'b0, 1'b1, '{8'h00, KIND_HEX, 1'b1}},
		'{CH_QUOTE, 1'b0, 1'b0, NO_RES},
		'{8'h7E, 1'b1, 1'b0, NO_RES}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	in_t  item;
	logic pop;
	logic empty;
	out_t result;

	dec_mode_t   dec_mode;
	logic [15:0] hex_acc;
	logic [1:0]  digit_cnt;
	logic [15:0] high_half;

	out_t decoded_q [$];
	out_t step_results [$];
	out_t want;
	logic typed_row;
	out_t typed_result;
	logic no_gaps;
	int   mismatch_count;
	int   random_sent;

	json_string_unescape_utf8 u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

	always #2 clk = ~clk;

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
		return -1;
	endfunction

	function automatic void add_result(ref out_t res[$], input logic [7:0] b,
			input logic [2:0] k);
		out_t r;
		r.out_byte = b;
		r.kind     = k;
		r.last     = 1'b0;
		res.push_back(r);
	endfunction

	function automatic void encode_cp(ref out_t res[$], input logic [20:0] cp);
		if (cp == 21'h0) begin
			return;
		end else if (cp < 21'h80) begin
			add_result(res, cp[7:0], KIND_DATA);
		end else if (cp < 21'h800) begin
			add_result(res, 8'hC0 | 8'(cp >> 6), KIND_DATA);
			add_result(res, 8'h80 | 8'(cp & 21'h3F), KIND_DATA);
		end else if (cp < 21'h10000) begin
			add_result(res, 8'hE0 | 8'(cp >> 12), KIND_DATA);
			add_result(res, 8'h80 | 8'((cp >> 6) & 21'h3F), KIND_DATA);
			add_result(res, 8'h80 | 8'(cp & 21'h3F), KIND_DATA);
		end else begin
			add_result(res, 8'hF0 | 8'(cp >> 18), KIND_DATA);
			add_result(res, 8'h80 | 8'((cp >> 12) & 21'h3F), KIND_DATA);
			add_result(res, 8'h80 | 8'((cp >> 6) & 21'h3F), KIND_DATA);
			add_result(res, 8'h80 | 8'(cp & 21'h3F), KIND_DATA);
		end
	endfunction

	task automatic decode_byte(input in_t x, ref out_t res[$]);
		logic [7:0]  c;
		logic        err;
		int          d;
		logic [20:0] cp;
		c   = x.in_byte;
		err = 1'b0;
		res.delete();
		case (dec_mode)
		M_BODY: begin
			if (c == CH_QUOTE) begin
				add_result(res, 8'h00, KIND_CLOSED);
				dec_mode = M_IDLE;
			end else if (c == CH_BSLASH) begin
				dec_mode = M_ESC;
			end else begin
				add_result(res, c, KIND_DATA);
			end
		end
		M_ESC: begin
			dec_mode = M_BODY;
			case (c)
			CH_QUOTE, CH_BSLASH, CH_SLASH: add_result(res, c, KIND_DATA);
			CH_B: add_result(res, 8'h08, KIND_DATA);
			CH_F: add_result(res, 8'h0C, KIND_DATA);
			CH_N: add_result(res, 8'h0A, KIND_DATA);
			CH_R: add_result(res, 8'h0D, KIND_DATA);
			CH_T: add_result(res, 8'h09, KIND_DATA);
			CH_U: begin
				dec_mode  = M_HEX;
				hex_acc   = '0;
				digit_cnt = '0;
			end
			default: begin
				add_result(res, 8'h00, KIND_ESC);
				dec_mode = M_IDLE;
				err      = 1'b1;
			end
			endcase
		end
		M_HEX, M_LOW_HEX: begin
			d = hex_digit(c);
			if (d < 0) begin
				add_result(res, 8'h00, KIND_HEX);
				dec_mode = M_IDLE;
				err      = 1'b1;
			end else begin
				hex_acc = {hex_acc[11:0], 4'(d)};
				if (digit_cnt < 2'd3) begin
					digit_cnt = digit_cnt + 2'd1;
				end else begin
					digit_cnt = '0;
					if (dec_mode == M_HEX) begin
						if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
							high_half = hex_acc;
							dec_mode  = M_WAIT_BS;
						end else begin
							encode_cp(res, {5'b0, hex_acc});
							dec_mode = M_BODY;
						end
					end else if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
						add_result(res, 8'h00, KIND_SURR);
						dec_mode = M_IDLE;
						err      = 1'b1;
					end else begin
						cp = 21'h10000 + {1'b0, high_half[9:0], hex_acc[9:0]};
						encode_cp(res, cp);
						dec_mode = M_BODY;
					end
				end
			end
		end
		M_WAIT_BS: begin
			if (c == CH_BSLASH) begin
				dec_mode = M_WAIT_U;
			end else begin
				add_result(res, 8'h00, KIND_SURR);
				dec_mode = M_IDLE;
				err      = 1'b1;
			end
		end
		M_WAIT_U: begin
			if (c == CH_U) begin
				dec_mode  = M_LOW_HEX;
				hex_acc   = '0;
				digit_cnt = '0;
			end else begin
				add_result(res, 8'h00, KIND_SURR);
				dec_mode = M_IDLE;
				err      = 1'b1;
			end
		end
		default: begin
			if (c == CH_QUOTE) begin
				dec_mode = M_BODY;
			end else begin
				add_result(res, 8'h00, KIND_START);
				dec_mode = M_IDLE;
				err      = 1'b1;
			end
		end
		endcase
		if (x.is_last_byte && !err && dec_mode != M_IDLE) begin
			add_result(res, 8'h00, KIND_UNTERM);
			dec_mode = M_IDLE;
		end
		if (res.size() > 0) res[res.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			decode_byte(item, step_results);
			if (typed_row) begin
				decoded_q.push_back(typed_result);
			end else begin
				foreach (step_results[i]) decoded_q.push_back(step_results[i]);
			end
		end
		if (arst_n && pop && !empty) begin
			if (decoded_q.size() == 0) begin
				$error("result with nothing expected: out_byte=%0h kind=%0d last=%0b",
					result.out_byte, result.kind, result.last);
				mismatch_count++;
			end else begin
				want = decoded_q.pop_front();
				if (result.out_byte !== want.out_byte) begin
					$error("out_byte: expected %0h, got %0h", want.out_byte, result.out_byte);
					mismatch_count++;
				end
				if (result.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, result.kind);
					mismatch_count++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, result.last);
					mismatch_count++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) pop <= no_gaps || ($urandom_range(99) >= 22);
	end

	task automatic send_byte(input logic [7:0] b, input logic lastb, input logic typed,
			input out_t typed_res);
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < 22) begin
			push <= 1'b0;
			@(negedge clk);
		end
		typed_row    = typed;
		typed_result = typed_res;
		push <= 1'b1;
		item <= {b, lastb};
		do @(posedge clk); while (full);
	endtask

	task automatic drain_results();
		@(negedge clk);
		push <= 1'b0;
		while (decoded_q.size() != 0) @(negedge clk);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'h30 + 8'(n);
		return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] byte_except(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] v;
		do v = 8'($urandom_range(255)); while (v == a || v == b);
		return v;
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] v;
		do v = 8'($urandom_range(255)); while (hex_digit(v) >= 0);
		return v;
	endfunction

	function automatic logic [7:0] odd_escape();
		logic [7:0] v;
		logic       known;
		do begin
			v     = 8'($urandom_range(255));
			known = (v == CH_U);
			foreach (ESC_LETTERS[i]) if (v == ESC_LETTERS[i]) known = 1'b1;
		end while (known);
		return v;
	endfunction

	function automatic void add_unicode(ref logic [7:0] lit[$], input logic [15:0] v);
		lit.push_back(CH_BSLASH);
		lit.push_back(CH_U);
		lit.push_back(hex_char(v[15:12]));
		lit.push_back(hex_char(v[11:8]));
		lit.push_back(hex_char(v[7:4]));
		lit.push_back(hex_char(v[3:0]));
	endfunction

	function automatic void add_partial_hex(ref logic [7:0] lit[$]);
		lit.push_back(CH_BSLASH);
		lit.push_back(CH_U);
		repeat ($urandom_range(3)) lit.push_back(hex_char(4'($urandom_range(15))));
		lit.push_back(non_hex_byte());
	endfunction

	function automatic void add_piece(ref logic [7:0] lit[$]);
		int          sel;
		logic [15:0] v;
		sel = $urandom_range(99);
		if (sel < 45) begin
			lit.push_back(byte_except(CH_QUOTE, CH_BSLASH));
		end else if (sel < 70) begin
			lit.push_back(CH_BSLASH);
			lit.push_back(ESC_LETTERS[$urandom_range(7)]);
		end else if (sel < 85) begin
			case ($urandom_range(4))
			0: v = 16'h0000;
			1: v = 16'($urandom_range(16'h7F, 1));
			2: v = 16'($urandom_range(16'h7FF, 16'h80));
			3: v = $urandom_range(1) ? 16'($urandom_range(16'hD7FF, 16'h800))
				: 16'($urandom_range(16'hFFFF, 16'hE000));
			default: v = 16'($urandom_range(16'hDFFF, 16'hDC00));
			endcase
			add_unicode(lit, v);
		end else begin
			add_unicode(lit, 16'($urandom_range(16'hDBFF, 16'hD800)));
			add_unicode(lit, 16'($urandom_range(16'hDFFF, 16'hDC00)));
		end
	endfunction

	function automatic void add_broken(ref logic [7:0] lit[$]);
		int          sel;
		logic [15:0] v;
		sel = $urandom_range(5);
		if (sel == 0) begin
			lit.push_back(CH_BSLASH);
			lit.push_back(odd_escape());
		end else if (sel == 1) begin
			add_partial_hex(lit);
		end else begin
			add_unicode(lit, 16'($urandom_range(16'hDBFF, 16'hD800)));
			case (sel)
			2: lit.push_back(byte_except(CH_BSLASH, CH_BSLASH));
			3: begin
				lit.push_back(CH_BSLASH);
				lit.push_back(byte_except(CH_U, CH_U));
			end
			4: begin
				do v = 16'($urandom_range(16'hFFFF)); while (v >= 16'hDC00 && v <= 16'hDFFF);
				add_unicode(lit, v);
			end
			default: add_partial_hex(lit);
			endcase
		end
	endfunction

	task automatic run_literal();
		logic [7:0] lit [$];
		logic       mark_last;
		int         cut;
		lit = {CH_QUOTE};
		repeat ($urandom_range(6, 1)) add_piece(lit);
		if ($urandom_range(99) < 20) add_broken(lit);
		else if ($urandom_range(99) < 85) lit.push_back(CH_QUOTE);
		mark_last = 1'b0;
		if ($urandom_range(99) < 15) begin
			cut = $urandom_range(lit.size() - 1);
			while (lit.size() > cut + 1) void'(lit.pop_back());
			mark_last = 1'b1;
		end
		foreach (lit[i]) begin
			send_byte(lit[i], mark_last && (i == lit.size() - 1), 1'b0, NO_RES);
			random_sent++;
		end
		if ($urandom_range(99) < 15) begin
			repeat ($urandom_range(3, 1)) begin
				send_byte(8'($urandom_range(255)), $urandom_range(9) == 0, 1'b0, NO_RES);
				random_sent++;
			end
		end
	endtask

	initial begin
		int lit_idx;
		arst_n         = 1'b0;
		push           = 1'b0;
		pop            = 1'b0;
		item           = '0;
		typed_row      = 1'b0;
		typed_result   = '0;
		no_gaps        = 1'b0;
		mismatch_count = 0;
		random_sent    = 0;
		dec_mode       = M_IDLE;
		hex_acc        = '0;
		digit_cnt      = '0;
		high_half      = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED_BYTES[i]) begin
			send_byte(DIRECTED_BYTES[i].b, DIRECTED_BYTES[i].lst, DIRECTED_BYTES[i].typed,
				DIRECTED_BYTES[i].want);
		end

		lit_idx = 0;
		while (random_sent < RANDOM_ITEMS) begin
			no_gaps = (lit_idx >= 12 && lit_idx < 18);
			if (lit_idx == 6 || $urandom_range(99) < 5) drain_results();
			run_literal();
			lit_idx++;
		end
		no_gaps = 1'b0;

		@(negedge clk);
		push <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && decoded_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

>>> files.f
+incdir+src
src/jsu_pkg.sv
src/jsu_front.sv
src/jsu_queue.sv
src/jsu_back.sv
src/json_string_unescape_utf8.sv
sim/tb.sv
